[src/flic_pkg.sv]
// ----------------------------------------------------------------------------
// flic_pkg
// Shared types, codes and helpers for the animation chunk decoder.
// ----------------------------------------------------------------------------
package flic_pkg;

    // default geometry
    localparam int LINE_PITCH_DEF    = 320;
    localparam int FRAME_BYTES_DEF   = 64000;
    localparam int PALETTE_BYTES_DEF = 768;

    // saturation limit of internal pixel addresses
    localparam logic [16:0] ADDR_MAX = 17'h1FFFF;

    // chunk type codes
    localparam logic [15:0] CT_COLOR_256 = 16'h0004;
    localparam logic [15:0] CT_SS2       = 16'h0007;
    localparam logic [15:0] CT_COLOR_64  = 16'h000b;
    localparam logic [15:0] CT_LC        = 16'h000c;
    localparam logic [15:0] CT_BRUN      = 16'h000f;

    // request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_DATA  = 1'b1;

    // configuration register indexes
    localparam logic CFG_OWN_PAL = 1'b0;
    localparam logic CFG_HEIGHT  = 1'b1;

    // result kinds
    localparam logic [1:0] RK_FILL    = 2'd0;
    localparam logic [1:0] RK_PALETTE = 2'd1;
    localparam logic [1:0] RK_NOTICE  = 2'd2;

    // parser phase
    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_HDR0    = 4'd1,
        PH_HDR1    = 4'd2,
        PH_HDR2    = 4'd3,
        PH_HDR3    = 4'd4,
        PH_LINE    = 4'd5,
        PH_LINE_HI = 4'd6,
        PH_SKIP    = 4'd7,
        PH_SIZE    = 4'd8,
        PH_RUN1    = 4'd9,
        PH_RUN2    = 4'd10,
        PH_LIT1    = 4'd11,
        PH_LIT2    = 4'd12,
        PH_PAL     = 4'd13
    } t_phase;

    // kind of chunk being parsed
    typedef enum logic [2:0] {
        AK_NONE = 3'd0,
        AK_PAL6 = 3'd1,
        AK_PAL8 = 3'd2,
        AK_LC   = 3'd3,
        AK_SS2  = 3'd4,
        AK_BRUN = 3'd5
    } t_akind;

    // saturate a wide address to 17 bits
    function automatic logic [16:0] sat_addr(input logic [31:0] v);
        return (v > 32'(ADDR_MAX)) ? ADDR_MAX : v[16:0];
    endfunction

endpackage

[src/flic_chunk_decoder.sv]
// ----------------------------------------------------------------------------
// flic_chunk_decoder
// Streaming decoder of animation chunks into palette writes and pixel fills.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  input   | in        | i_valid / o_stall       | req_type, chunk_type, data_byte
//  result  | out       | o_valid / i_stall       | kind, position, values, count, flags
//  config  | in        | i_cfg_valid / o_cfg_ready | cfg_index, cfg_data
//
//  one item per cycle while o_stall is low; its result shows in the cycle after it is accepted
//  the parser state updates in the accept cycle; the result register is the only stage
//  o_stall is high only while a result waits and the result side stalls
//  synchronous active-low reset clears the parser and the result valid flag
//  config is always ready
// ----------------------------------------------------------------------------
module flic_chunk_decoder #(
    parameter int LINE_PITCH    = flic_pkg::LINE_PITCH_DEF,
    parameter int FRAME_BYTES   = flic_pkg::FRAME_BYTES_DEF,
    parameter int PALETTE_BYTES = flic_pkg::PALETTE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [15:0] i_chunk_type,
    input  logic [7:0]  i_data_byte,
    // result items
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [15:0] o_position,
    output logic [7:0]  o_first_value,
    output logic [7:0]  o_second_value,
    output logic [7:0]  o_repeat_count,
    output logic        o_paired,
    output logic        o_clipped,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    // configuration registers
    logic        r_own_pal;
    logic [7:0]  r_height;

    // parser state
    flic_pkg::t_phase r_phase,  n_phase;
    flic_pkg::t_akind r_akind,  n_akind;
    logic [15:0] r_line,    n_line;
    logic [15:0] r_lines,   n_lines;
    logic [15:0] r_packets, n_packets;
    logic [16:0] r_addr,    n_addr;
    logic [16:0] r_skip,    n_skip;
    logic [7:0]  r_lit,     n_lit;
    logic [7:0]  r_held,    n_held;
    logic [17:0] r_pal_left, n_pal_left;
    logic [9:0]  r_pal_pos, n_pal_pos;

    // result register
    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [15:0] r_pos;
    logic [7:0]  r_v1, r_v2, r_rep;
    logic        r_pair, r_clip;

    // result of the current item
    logic        res_valid;
    logic [1:0]  res_kind;
    logic [15:0] res_pos;
    logic [7:0]  res_v1, res_v2, res_rep;
    logic        res_pair, res_clip;

    logic in_acc;

    assign o_stall     = r_out_valid & i_stall;
    assign in_acc      = i_valid & ~o_stall;
    assign o_cfg_ready = 1'b1;

    // parser next state and result
    always_comb begin
        logic        f_begin, f_endpkt, f_endline, f_fill, f_litdec, f_pair;
        logic [15:0] beg_count, w, pk;
        logic [16:0] beg_extra;
        logic [7:0]  fv1, fv2, frep;
        logic [8:0]  pixels;
        logic [17:0] fend;
        logic        low, lit;
        logic [7:0]  lcount;

        f_begin   = 1'b0;
        f_endpkt  = 1'b0;
        f_endline = 1'b0;
        f_fill    = 1'b0;
        f_litdec  = 1'b0;
        f_pair    = 1'b0;
        beg_count = '0;
        beg_extra = '0;
        fv1       = '0;
        fv2       = '0;
        frep      = '0;
        pixels    = '0;
        fend      = '0;
        pk        = '0;
        w         = {i_data_byte, r_held};
        low       = ~i_data_byte[7];
        lit       = 1'b0;
        lcount    = '0;

        n_phase    = r_phase;
        n_akind    = r_akind;
        n_line     = r_line;
        n_lines    = r_lines;
        n_packets  = r_packets;
        n_addr     = r_addr;
        n_skip     = r_skip;
        n_lit      = r_lit;
        n_held     = r_held;
        n_pal_left = r_pal_left;
        n_pal_pos  = r_pal_pos;

        res_valid = 1'b0;
        res_kind  = flic_pkg::RK_FILL;
        res_pos   = '0;
        res_v1    = '0;
        res_v2    = '0;
        res_rep   = '0;
        res_pair  = 1'b0;
        res_clip  = 1'b0;

        if (i_req_type == flic_pkg::REQ_START) begin
            // chunk start
            n_phase = flic_pkg::PH_IDLE;
            n_akind = flic_pkg::AK_NONE;
            if (i_chunk_type == flic_pkg::CT_COLOR_64 ||
                i_chunk_type == flic_pkg::CT_COLOR_256) begin
                if (!r_own_pal) begin
                    n_akind = (i_chunk_type == flic_pkg::CT_COLOR_64) ?
                              flic_pkg::AK_PAL6 : flic_pkg::AK_PAL8;
                    n_phase = flic_pkg::PH_HDR0;
                end
            end else if (i_chunk_type == flic_pkg::CT_LC) begin
                n_akind = flic_pkg::AK_LC;
                n_phase = flic_pkg::PH_HDR0;
            end else if (i_chunk_type == flic_pkg::CT_SS2) begin
                n_akind = flic_pkg::AK_SS2;
                n_phase = flic_pkg::PH_HDR0;
                n_line  = '0;
                n_skip  = '0;
            end else if (i_chunk_type == flic_pkg::CT_BRUN) begin
                n_akind = flic_pkg::AK_BRUN;
                n_line  = '0;
                n_lines = 16'(r_height);
                n_phase = (r_height == 8'd0) ? flic_pkg::PH_IDLE : flic_pkg::PH_LINE;
            end else begin
                res_valid = 1'b1;
                res_kind  = flic_pkg::RK_NOTICE;
                res_pos   = i_chunk_type;
            end
        end else begin
            // data byte
            unique case (r_phase)
                flic_pkg::PH_HDR0: begin
                    n_held  = i_data_byte;
                    n_phase = flic_pkg::PH_HDR1;
                end
                flic_pkg::PH_HDR1: begin
                    if (r_akind == flic_pkg::AK_PAL6 || r_akind == flic_pkg::AK_PAL8) begin
                        n_pal_left = {2'b00, r_held, i_data_byte}
                                   + {1'b0, r_held, i_data_byte, 1'b0};
                        n_phase    = flic_pkg::PH_HDR2;
                    end else if (r_akind == flic_pkg::AK_LC) begin
                        n_line  = w;
                        n_phase = flic_pkg::PH_HDR2;
                    end else begin
                        n_lines = w;
                        n_phase = (w == 16'd0) ? flic_pkg::PH_IDLE : flic_pkg::PH_LINE;
                    end
                end
                flic_pkg::PH_HDR2: begin
                    n_held  = i_data_byte;
                    n_phase = flic_pkg::PH_HDR3;
                end
                flic_pkg::PH_HDR3: begin
                    if (r_akind == flic_pkg::AK_PAL6 || r_akind == flic_pkg::AK_PAL8) begin
                        n_pal_pos = '0;
                        n_phase   = (r_pal_left == 18'd0) ?
                                    flic_pkg::PH_IDLE : flic_pkg::PH_PAL;
                    end else begin
                        n_lines = w;
                        n_phase = (w == 16'd0) ? flic_pkg::PH_IDLE : flic_pkg::PH_LINE;
                    end
                end
                flic_pkg::PH_PAL: begin
                    if (r_pal_pos < 10'(PALETTE_BYTES)) begin
                        res_valid = 1'b1;
                        res_kind  = flic_pkg::RK_PALETTE;
                        res_pos   = 16'(r_pal_pos);
                        res_v1    = (r_akind == flic_pkg::AK_PAL8) ?
                                    {2'b00, i_data_byte[7:2]} : i_data_byte;
                        n_pal_pos = r_pal_pos + 10'd1;
                    end
                    n_pal_left = r_pal_left - 18'd1;
                    if (r_pal_left == 18'd1) n_phase = flic_pkg::PH_IDLE;
                end
                flic_pkg::PH_LINE: begin
                    if (r_akind == flic_pkg::AK_SS2) begin
                        n_held  = i_data_byte;
                        n_phase = flic_pkg::PH_LINE_HI;
                    end else begin
                        f_begin   = 1'b1;
                        beg_count = 16'(i_data_byte);
                    end
                end
                flic_pkg::PH_LINE_HI: begin
                    if (w[15]) begin
                        n_skip  = flic_pkg::sat_addr(32'(r_skip)
                                  + (32'h10000 - 32'(w)) * 32'(LINE_PITCH));
                        n_phase = flic_pkg::PH_LINE;
                    end else begin
                        f_begin   = 1'b1;
                        beg_count = w;
                        beg_extra = r_skip;
                    end
                end
                flic_pkg::PH_SKIP: begin
                    n_addr  = flic_pkg::sat_addr(32'(r_addr) + 32'(i_data_byte));
                    n_phase = flic_pkg::PH_SIZE;
                end
                flic_pkg::PH_SIZE: begin
                    lit    = (r_akind == flic_pkg::AK_BRUN) ? ~low : low;
                    lcount = low ? i_data_byte : (~i_data_byte + 8'd1);
                    n_lit  = lcount;
                    if (lit) begin
                        if (lcount == 8'd0) f_endpkt = 1'b1;
                        else n_phase = flic_pkg::PH_LIT1;
                    end else begin
                        n_phase = flic_pkg::PH_RUN1;
                    end
                end
                flic_pkg::PH_RUN1: begin
                    if (r_akind == flic_pkg::AK_SS2) begin
                        n_held  = i_data_byte;
                        n_phase = flic_pkg::PH_RUN2;
                    end else begin
                        f_fill   = 1'b1;
                        fv1      = i_data_byte;
                        frep     = r_lit;
                        f_endpkt = 1'b1;
                    end
                end
                flic_pkg::PH_RUN2: begin
                    f_fill   = 1'b1;
                    f_pair   = 1'b1;
                    fv1      = r_held;
                    fv2      = i_data_byte;
                    frep     = r_lit;
                    f_endpkt = 1'b1;
                end
                flic_pkg::PH_LIT1: begin
                    if (r_akind == flic_pkg::AK_SS2) begin
                        n_held  = i_data_byte;
                        n_phase = flic_pkg::PH_LIT2;
                    end else begin
                        f_fill   = 1'b1;
                        fv1      = i_data_byte;
                        frep     = 8'd1;
                        f_litdec = 1'b1;
                    end
                end
                flic_pkg::PH_LIT2: begin
                    f_fill   = 1'b1;
                    f_pair   = 1'b1;
                    fv1      = r_held;
                    fv2      = i_data_byte;
                    frep     = 8'd1;
                    f_litdec = 1'b1;
                end
                default: begin
                end
            endcase
        end

        // pixel fill command
        if (f_fill) begin
            pixels    = f_pair ? {frep, 1'b0} : {1'b0, frep};
            fend      = 18'(r_addr) + 18'(pixels);
            res_valid = 1'b1;
            res_kind  = flic_pkg::RK_FILL;
            res_pos   = r_addr[16] ? 16'hFFFF : r_addr[15:0];
            res_v1    = fv1;
            res_v2    = fv2;
            res_rep   = frep;
            res_pair  = f_pair;
            res_clip  = fend > 18'(FRAME_BYTES);
            n_addr    = flic_pkg::sat_addr(32'(fend));
        end

        // literal countdown
        if (f_litdec) begin
            n_lit = r_lit - 8'd1;
            if (r_lit == 8'd1) f_endpkt = 1'b1;
            else n_phase = flic_pkg::PH_LIT1;
        end

        // line start
        if (f_begin) begin
            n_packets = beg_count;
            n_addr    = flic_pkg::sat_addr(32'(r_line) * 32'(LINE_PITCH) + 32'(beg_extra));
            if (beg_count == 16'd0) f_endline = 1'b1;
            else n_phase = (r_akind == flic_pkg::AK_BRUN) ?
                           flic_pkg::PH_SIZE : flic_pkg::PH_SKIP;
        end

        // packet end
        if (f_endpkt) begin
            pk        = r_packets - 16'd1;
            n_packets = pk;
            if (pk == 16'd0) f_endline = 1'b1;
            else n_phase = (r_akind == flic_pkg::AK_BRUN) ?
                           flic_pkg::PH_SIZE : flic_pkg::PH_SKIP;
        end

        // line end
        if (f_endline) begin
            n_lines = r_lines - 16'd1;
            if (r_line != 16'hFFFF) n_line = r_line + 16'd1;
            n_phase = (r_lines == 16'd1) ? flic_pkg::PH_IDLE : flic_pkg::PH_LINE;
        end

        // bytes while idle are dropped
        if (i_req_type == flic_pkg::REQ_DATA && r_phase == flic_pkg::PH_IDLE) begin
            res_valid = 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_pal <= 1'b0;
            r_height  <= 8'd200;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == flic_pkg::CFG_OWN_PAL) r_own_pal <= i_cfg_data[0];
            if (i_cfg_index == flic_pkg::CFG_HEIGHT)  r_height  <= i_cfg_data;
        end
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= flic_pkg::PH_IDLE;
            r_akind    <= flic_pkg::AK_NONE;
            r_line     <= '0;
            r_lines    <= '0;
            r_packets  <= '0;
            r_addr     <= '0;
            r_skip     <= '0;
            r_lit      <= '0;
            r_held     <= '0;
            r_pal_left <= '0;
            r_pal_pos  <= '0;
        end else if (in_acc) begin
            r_phase    <= n_phase;
            r_akind    <= n_akind;
            r_line     <= n_line;
            r_lines    <= n_lines;
            r_packets  <= n_packets;
            r_addr     <= n_addr;
            r_skip     <= n_skip;
            r_lit      <= n_lit;
            r_held     <= n_held;
            r_pal_left <= n_pal_left;
            r_pal_pos  <= n_pal_pos;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= res_valid;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (in_acc && res_valid) begin
            r_kind <= res_kind;
            r_pos  <= res_pos;
            r_v1   <= res_v1;
            r_v2   <= res_v2;
            r_rep  <= res_rep;
            r_pair <= res_pair;
            r_clip <= res_clip;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_kind;
    assign o_position     = r_pos;
    assign o_first_value  = r_v1;
    assign o_second_value = r_v2;
    assign o_repeat_count = r_rep;
    assign o_paired       = r_pair;
    assign o_clipped      = r_clip;

endmodule

[sim/tb_flic_chunk_decoder.sv]
// ----------------------------------------------------------------------------
// tb_flic_chunk_decoder
// Self-checking bench for the animation chunk decoder. Chunks of every kind
// are built as byte streams, some cut short or mixed with noise, and sent
// with random gaps while the result side stalls at random. An item-level
// predictor of the parser produces the commands each accepted item should
// give; every result is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_flic_chunk_decoder;

    typedef struct {
        logic        req;
        logic [15:0] ctype;
        logic [7:0]  dbyte;
        int          gap;
        bit          drain;
    } t_item;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] pos;
        logic [7:0]  v1;
        logic [7:0]  v2;
        logic [7:0]  rep;
        logic        pair;
        logic        clip;
    } t_cmd;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_req_type;
    logic [15:0] i_chunk_type;
    logic [7:0]  i_data_byte;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_kind;
    logic [15:0] o_position;
    logic [7:0]  o_first_value;
    logic [7:0]  o_second_value;
    logic [7:0]  o_repeat_count;
    logic        o_paired;
    logic        o_clipped;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [7:0]  i_cfg_data;

    flic_chunk_decoder uut (.*);

    // clock
    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    t_item pend_items[$];
    t_item chunk_buf[$];
    t_cmd  cmd_q[$];
    int    errors = 0;
    int    n_items = 0;
    int    n_cmds = 0;
    int    n_chunks = 0;
    int    in_gap = 0;
    int    out_gap = 0;
    int    queued = 0;

    // shadow configuration and parser state
    logic             own_pal;
    logic [7:0]       height;
    flic_pkg::t_phase ph;
    flic_pkg::t_akind ak;
    logic [15:0]      line_no;
    logic [15:0]      lines_left;
    logic [15:0]      pk_left;
    logic [16:0]      pix;
    logic [16:0]      skip;
    logic [7:0]       lit_left;
    logic [7:0]       held;
    logic [17:0]      pal_left;
    logic [9:0]       pal_pos;

    function automatic logic [16:0] clamp17(int unsigned v);
        return (v > 32'h1FFFF) ? 17'h1FFFF : v[16:0];
    endfunction

    task automatic push_cmd(logic [1:0] k, logic [15:0] p, logic [7:0] a, logic [7:0] b,
                            logic [7:0] r, logic pr, logic c);
        t_cmd e;
        e.kind = k; e.pos = p; e.v1 = a; e.v2 = b; e.rep = r; e.pair = pr; e.clip = c;
        cmd_q.push_back(e);
    endtask

    task automatic fill(logic [7:0] a, logic [7:0] b, logic [7:0] r, logic pr);
        int unsigned px;
        int unsigned ad;
        px = pr ? 2 * r : r;
        ad = pix;
        push_cmd(flic_pkg::RK_FILL, (ad > 65535) ? 16'hFFFF : ad[15:0], a, pr ? b : 8'd0,
                 r, pr, (ad + px > flic_pkg::FRAME_BYTES_DEF));
        pix = clamp17(ad + px);
    endtask

    task automatic line_done();
        lines_left = lines_left - 16'd1;
        if (line_no != 16'hFFFF) line_no = line_no + 16'd1;
        ph = (lines_left == 0) ? flic_pkg::PH_IDLE : flic_pkg::PH_LINE;
    endtask

    task automatic line_open(logic [15:0] cnt, logic [16:0] extra);
        pk_left = cnt;
        pix = clamp17(int'(line_no) * flic_pkg::LINE_PITCH_DEF + int'(extra));
        if (pk_left == 0) line_done();
        else ph = (ak == flic_pkg::AK_BRUN) ? flic_pkg::PH_SIZE : flic_pkg::PH_SKIP;
    endtask

    task automatic packet_done();
        pk_left = pk_left - 16'd1;
        if (pk_left == 0) line_done();
        else ph = (ak == flic_pkg::AK_BRUN) ? flic_pkg::PH_SIZE : flic_pkg::PH_SKIP;
    endtask

    task automatic literal_next();
        lit_left = lit_left - 8'd1;
        if (lit_left == 0) packet_done();
        else ph = flic_pkg::PH_LIT1;
    endtask

    // decode one accepted item into its expected commands
    task automatic decode_item(t_item it);
        logic [7:0]  b;
        logic [15:0] w;
        logic        low;
        logic        lit;
        logic        pal;
        b = it.dbyte;
        pal = (ak == flic_pkg::AK_PAL6) || (ak == flic_pkg::AK_PAL8);
        if (it.req == flic_pkg::REQ_START) begin
            ph = flic_pkg::PH_IDLE;
            ak = flic_pkg::AK_NONE;
            if (it.ctype == flic_pkg::CT_COLOR_64 || it.ctype == flic_pkg::CT_COLOR_256) begin
                if (!own_pal) begin
                    ak = (it.ctype == flic_pkg::CT_COLOR_64) ?
                         flic_pkg::AK_PAL6 : flic_pkg::AK_PAL8;
                    ph = flic_pkg::PH_HDR0;
                end
            end else if (it.ctype == flic_pkg::CT_LC) begin
                ak = flic_pkg::AK_LC; ph = flic_pkg::PH_HDR0;
            end else if (it.ctype == flic_pkg::CT_SS2) begin
                ak = flic_pkg::AK_SS2; ph = flic_pkg::PH_HDR0; line_no = 0; skip = 0;
            end else if (it.ctype == flic_pkg::CT_BRUN) begin
                ak = flic_pkg::AK_BRUN; line_no = 0; lines_left = {8'd0, height};
                ph = (lines_left == 0) ? flic_pkg::PH_IDLE : flic_pkg::PH_LINE;
            end else begin
                push_cmd(flic_pkg::RK_NOTICE, it.ctype, 0, 0, 0, 0, 0);
            end
            return;
        end
        case (ph)
            flic_pkg::PH_HDR0: begin
                held = b; ph = flic_pkg::PH_HDR1;
            end
            flic_pkg::PH_HDR1: begin
                if (pal) begin
                    pal_left = 18'({held, b}) * 18'd3;
                    ph = flic_pkg::PH_HDR2;
                end else if (ak == flic_pkg::AK_LC) begin
                    line_no = {b, held};
                    ph = flic_pkg::PH_HDR2;
                end else begin
                    lines_left = {b, held};
                    ph = (lines_left == 0) ? flic_pkg::PH_IDLE : flic_pkg::PH_LINE;
                end
            end
            flic_pkg::PH_HDR2: begin
                held = b; ph = flic_pkg::PH_HDR3;
            end
            flic_pkg::PH_HDR3: begin
                if (pal) begin
                    pal_pos = 0;
                    ph = (pal_left == 0) ? flic_pkg::PH_IDLE : flic_pkg::PH_PAL;
                end else begin
                    lines_left = {b, held};
                    ph = (lines_left == 0) ? flic_pkg::PH_IDLE : flic_pkg::PH_LINE;
                end
            end
            flic_pkg::PH_PAL: begin
                if (pal_pos < flic_pkg::PALETTE_BYTES_DEF) begin
                    push_cmd(flic_pkg::RK_PALETTE, {6'd0, pal_pos},
                             (ak == flic_pkg::AK_PAL8) ? (b >> 2) : b, 0, 0, 0, 0);
                    pal_pos = pal_pos + 10'd1;
                end
                pal_left = pal_left - 18'd1;
                if (pal_left == 0) ph = flic_pkg::PH_IDLE;
            end
            flic_pkg::PH_LINE: begin
                if (ak == flic_pkg::AK_SS2) begin
                    held = b; ph = flic_pkg::PH_LINE_HI;
                end else begin
                    line_open({8'd0, b}, 17'd0);
                end
            end
            flic_pkg::PH_LINE_HI: begin
                w = {b, held};
                if (w[15]) begin
                    skip = clamp17(int'(skip)
                                   + (65536 - int'(w)) * flic_pkg::LINE_PITCH_DEF);
                    ph = flic_pkg::PH_LINE;
                end else begin
                    line_open(w, skip);
                end
            end
            flic_pkg::PH_SKIP: begin
                pix = clamp17(int'(pix) + int'(b));
                ph = flic_pkg::PH_SIZE;
            end
            flic_pkg::PH_SIZE: begin
                low = (b < 8'h80);
                lit = (ak == flic_pkg::AK_BRUN) ? !low : low;
                lit_left = low ? b : 8'(256 - int'(b));
                if (lit) begin
                    if (lit_left == 0) packet_done();
                    else ph = flic_pkg::PH_LIT1;
                end else begin
                    ph = flic_pkg::PH_RUN1;
                end
            end
            flic_pkg::PH_RUN1: begin
                if (ak == flic_pkg::AK_SS2) begin
                    held = b; ph = flic_pkg::PH_RUN2;
                end else begin
                    fill(b, 0, lit_left, 0);
                    packet_done();
                end
            end
            flic_pkg::PH_RUN2: begin
                fill(held, b, lit_left, 1);
                packet_done();
            end
            flic_pkg::PH_LIT1: begin
                if (ak == flic_pkg::AK_SS2) begin
                    held = b; ph = flic_pkg::PH_LIT2;
                end else begin
                    fill(b, 0, 8'd1, 0);
                    literal_next();
                end
            end
            flic_pkg::PH_LIT2: begin
                fill(held, b, 8'd1, 1);
                literal_next();
            end
            default: ;
        endcase
    endtask

    // input driver
    int wait_cnt = 0;
    t_item cur;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            wait_cnt = 0;
        end else begin
            if (i_valid && !o_stall) begin
                decode_item(cur);
                n_items++;
            end
            if (!i_valid || !o_stall) begin
                if (pend_items.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (wait_cnt < pend_items[0].gap ||
                             (pend_items[0].drain && cmd_q.size() != 0)) begin
                    if (wait_cnt < pend_items[0].gap) wait_cnt++;
                    i_valid <= 1'b0;
                end else begin
                    cur = pend_items.pop_front();
                    wait_cnt = 0;
                    i_req_type   <= cur.req;
                    i_chunk_type <= cur.ctype;
                    i_data_byte  <= cur.dbyte;
                    i_valid      <= 1'b1;
                end
            end
        end
    end

    task automatic report(string what, int got, int want);
        if (errors < 30)
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result monitor
    int hold = 0;
    t_cmd want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold = 0;
        end else begin
            if (o_valid && !i_stall) begin
                n_cmds++;
                if (cmd_q.size() == 0) begin
                    report("unexpected result kind", o_kind, -1);
                end else begin
                    want = cmd_q.pop_front();
                    if (o_kind != want.kind) report("kind", o_kind, want.kind);
                    if (o_position != want.pos) report("position", o_position, want.pos);
                    if (o_first_value != want.v1) report("first_value", o_first_value, want.v1);
                    if (o_second_value != want.v2)
                        report("second_value", o_second_value, want.v2);
                    if (o_repeat_count != want.rep)
                        report("repeat_count", o_repeat_count, want.rep);
                    if (o_paired != want.pair) report("paired", o_paired, want.pair);
                    if (o_clipped != want.clip) report("clipped", o_clipped, want.clip);
                end
                hold = $urandom_range(0, out_gap);
            end
            if (hold > 0) begin
                hold--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // stream building
    task automatic put(logic req, logic [15:0] t, logic [7:0] b);
        t_item it;
        it.req = req; it.ctype = t; it.dbyte = b;
        it.gap = $urandom_range(0, in_gap); it.drain = 0;
        chunk_buf.push_back(it);
    endtask

    task automatic put16(int v);
        put(flic_pkg::REQ_DATA, 16'($urandom), 8'(v));
        put(flic_pkg::REQ_DATA, 16'($urandom), 8'(v >> 8));
    endtask

    task automatic put_byte(int v);
        put(flic_pkg::REQ_DATA, 16'($urandom), 8'(v));
    endtask

    task automatic flush_chunk(bit may_cut);
        int keep;
        keep = chunk_buf.size();
        if (may_cut && keep > 1 && $urandom_range(0, 9) == 0)
            keep = $urandom_range(1, keep - 1);
        for (int k = 0; k < keep; k++) pend_items.push_back(chunk_buf[k]);
        queued += keep;
        chunk_buf.delete();
        n_chunks++;
    endtask

    task automatic gen_palette(logic [15:0] t, int cnt);
        put(flic_pkg::REQ_START, t, 8'($urandom));
        put_byte(cnt >> 8);
        put_byte(cnt);
        put_byte($urandom);
        put_byte($urandom);
        for (int k = 0; k < cnt * 3; k++) put_byte($urandom);
    endtask

    task automatic gen_lc();
        int nl;
        int np;
        int n;
        put(flic_pkg::REQ_START, flic_pkg::CT_LC, 8'($urandom));
        put16(($urandom_range(0, 7) == 0) ? $urandom_range(65530, 65535)
                                          : $urandom_range(0, 205));
        nl = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
        put16(nl);
        for (int l = 0; l < nl; l++) begin
            np = $urandom_range(0, 3);
            put_byte(np);
            for (int p = 0; p < np; p++) begin
                put_byte($urandom);
                if ($urandom_range(0, 1)) begin
                    n = ($urandom_range(0, 11) == 0) ? 127 : $urandom_range(0, 4);
                    put_byte(n);
                    for (int k = 0; k < n; k++) put_byte($urandom);
                end else begin
                    n = ($urandom_range(0, 11) == 0) ? 128 : $urandom_range(1, 8);
                    put_byte(256 - n);
                    put_byte($urandom);
                end
            end
        end
    endtask

    task automatic gen_ss2();
        int nl;
        int np;
        int n;
        put(flic_pkg::REQ_START, flic_pkg::CT_SS2, 8'($urandom));
        nl = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
        put16(nl);
        for (int l = 0; l < nl; l++) begin
            while ($urandom_range(0, 2) == 0)
                put16(($urandom_range(0, 9) == 0) ? 16'h8000
                                                  : 65536 - $urandom_range(1, 40));
            np = $urandom_range(0, 3);
            put16(np);
            for (int p = 0; p < np; p++) begin
                put_byte($urandom);
                if ($urandom_range(0, 1)) begin
                    n = $urandom_range(0, 3);
                    put_byte(n);
                    for (int k = 0; k < 2 * n; k++) put_byte($urandom);
                end else begin
                    n = ($urandom_range(0, 11) == 0) ? 128 : $urandom_range(1, 8);
                    put_byte(256 - n);
                    put_byte($urandom);
                    put_byte($urandom);
                end
            end
        end
    endtask

    task automatic gen_brun();
        int np;
        int n;
        put(flic_pkg::REQ_START, flic_pkg::CT_BRUN, 8'($urandom));
        for (int l = 0; l < height; l++) begin
            np = (height > 8 && $urandom_range(0, 19) != 0) ? 0 : $urandom_range(0, 2);
            put_byte(np);
            for (int p = 0; p < np; p++) begin
                if ($urandom_range(0, 1)) begin
                    n = ($urandom_range(0, 11) == 0) ? 127 : $urandom_range(0, 6);
                    put_byte(n);
                    put_byte($urandom);
                end else begin
                    n = ($urandom_range(0, 11) == 0) ? 128 : $urandom_range(1, 5);
                    put_byte(256 - n);
                    for (int k = 0; k < n; k++) put_byte($urandom);
                end
            end
        end
    endtask

    task automatic cfg_write(logic idx, logic [7:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == flic_pkg::CFG_OWN_PAL) own_pal = val[0];
        else height = val;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk); while (pend_items.size() != 0 || i_valid || cmd_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // stimulus
    int target;
    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_req_type = flic_pkg::REQ_START;
        i_chunk_type = 16'd0;
        i_data_byte = 8'd0;
        i_cfg_valid = 1'b0;
        i_cfg_index = flic_pkg::CFG_OWN_PAL;
        i_cfg_data = 8'd0;
        own_pal = 1'b0; height = 8'd200;
        ph = flic_pkg::PH_IDLE; ak = flic_pkg::AK_NONE;
        line_no = 0; lines_left = 0; pk_left = 0; pix = 0; skip = 0;
        lit_left = 0; held = 0; pal_left = 0; pal_pos = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle bytes, notices, palette edges, zero counts, run of zero
        cfg_write(flic_pkg::CFG_OWN_PAL, 8'd0);
        cfg_write(flic_pkg::CFG_HEIGHT, 8'd1);
        put_byte(8'hFF);
        put(flic_pkg::REQ_START, 16'hFFFF, 8'h00);
        put(flic_pkg::REQ_START, 16'h0000, 8'hFF);
        gen_palette(flic_pkg::CT_COLOR_64, 1);
        chunk_buf[8].dbyte = 8'h00; chunk_buf[9].dbyte = 8'hFF; chunk_buf[10].dbyte = 8'h80;
        flush_chunk(0);
        gen_palette(flic_pkg::CT_COLOR_256, 0);
        flush_chunk(0);
        put(flic_pkg::REQ_START, flic_pkg::CT_BRUN, 8'h00);
        put_byte(1);
        put_byte(0);
        put_byte(8'hAA);
        put(flic_pkg::REQ_START, flic_pkg::CT_LC, 8'h00);
        put16(0);
        put16(0);
        flush_chunk(0);
        wait_idle();

        // random phases, each with its own register setting
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    cfg_write(flic_pkg::CFG_OWN_PAL, 8'd0);
                    cfg_write(flic_pkg::CFG_HEIGHT, 8'd2);
                end
                1: begin
                    cfg_write(flic_pkg::CFG_OWN_PAL, 8'd1);
                    cfg_write(flic_pkg::CFG_HEIGHT, 8'd0);
                end
                2: begin
                    cfg_write(flic_pkg::CFG_OWN_PAL, 8'd0);
                    cfg_write(flic_pkg::CFG_HEIGHT, 8'd200);
                end
                3: begin
                    cfg_write(flic_pkg::CFG_OWN_PAL, 8'd1);
                    cfg_write(flic_pkg::CFG_HEIGHT, 8'd1);
                end
                default: begin
                    cfg_write(flic_pkg::CFG_OWN_PAL, 8'd0);
                    cfg_write(flic_pkg::CFG_HEIGHT, 8'd3);
                end
            endcase
            target = queued + 100;
            if (phase == 0) begin
                // palette overflow: one entry more than the table holds
                gen_palette(flic_pkg::CT_COLOR_256, 257);
                flush_chunk(0);
            end
            while (queued < target) begin
                in_gap  = $urandom_range(0, 1) ? 13 : 0;
                out_gap = $urandom_range(0, 1) ? 13 : 0;
                case ($urandom_range(0, 9))
                    0, 1: gen_lc();
                    2, 3: gen_ss2();
                    4: gen_brun();
                    5: gen_palette(flic_pkg::CT_COLOR_64, $urandom_range(0, 4));
                    6: gen_palette(flic_pkg::CT_COLOR_256, $urandom_range(0, 4));
                    7: put(flic_pkg::REQ_START, 16'($urandom), 8'($urandom));
                    8: repeat ($urandom_range(1, 3)) put_byte($urandom);
                    default: begin
                        put(flic_pkg::REQ_START, 16'($urandom_range(0, 15)), 8'($urandom));
                        repeat ($urandom_range(1, 6)) put_byte($urandom);
                    end
                endcase
                if (phase == 2 && chunk_buf.size() > 0 &&
                    (n_chunks % 7 == 0 || queued == target - 100))
                    chunk_buf[0].drain = 1;
                flush_chunk(1);
            end
            wait_idle();
        end

        in_gap = 0;
        out_gap = 0;
        wait_idle();
        repeat (10) @(posedge i_clk);
        $display("covered %0d items in %0d chunks, %0d results checked, %0d errors",
                 n_items, n_chunks, n_cmds, errors);
        $display("register settings: own palette both ways, heights 0 1 2 3 200");
        if (errors == 0 && cmd_q.size() == 0) begin
            $display("PASS");
        end else begin
            if (cmd_q.size() != 0) $display("%0d expected results never came", cmd_q.size());
            $display("FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20000000;
        $display("timeout");
        $display("FAIL");
        $finish;
    end

endmodule
